### hw/rtl/pcodec_pkg.sv
// Percent codec package: shared types, character constants and classifiers.
// Used by every module of the percent codec; no dependencies of its own.
package pcodec_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_DECODE_MODE = 1'b0,
		REG_SLASH_PASS  = 1'b1
	} reg_idx_t;

	// escape tracking in decode mode
	typedef enum logic [2:0] {
		PS_IDLE = 3'b001,
		PS_PCT  = 3'b010,
		PS_DIG  = 3'b100
	} pend_t;

	// one classified input word: up to three output bytes, lowest slot first
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            last;
	} entry_t;

	function automatic logic is_unreserved(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
			|| (c >= 8'h30 && c <= 8'h39)
			|| c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E;
	endfunction

	// value of a hex digit; bit 4 set when c is not one
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h10;
		if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
		else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
		else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
		return v[4:0];
	endfunction

	// uppercase hex character of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [3:0] m;
		m = d & NIBBLE_MASK;
		return (m < 4'd10) ? (8'h30 + {4'h0, m}) : (8'h37 + {4'h0, m});
	endfunction

endpackage

### hw/rtl/percent_codec.sv
// Percent codec top level: stream ports, configuration write port and the
// front end, entry queue and output serialiser. Uses pcodec_pkg.
//
// Byte-stream percent encoder/decoder. In encode mode (decode_mode = 0) the
// unreserved characters A-Z a-z 0-9 - . _ ~ pass through, '/' too while the
// slash pass-through register is 1, and every other byte becomes '%' and two
// uppercase hex digits. In decode mode '%' and two hex digits of either case
// become one byte; a broken escape, or one that spells NUL, comes out
// literally and the bytes after it are handled again as ordinary input. A
// word with tlast set flushes any held escape. Each input word gives zero to
// three output words; the output side carries one byte a cycle while
// m_tready is high, so throughput is set by the serialiser, and a decode
// word that only extends an escape gives no output and takes no queue slot.
// The first output byte of a word passes through a queue slot and then the
// output register before it is on m_tdata, where it can be taken.
// The front end classifies a word in the cycle it is accepted and parks it
// in a QDEPTH-entry queue, so input is taken while earlier results still
// wait at the output. Write the configuration only while idle; writing
// decode_mode drops a held escape.
module percent_codec import pcodec_pkg::*; #(
	parameter int QDEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: index 0 decode_mode, index 1 slash pass-through
	input  logic       cfg_we,
	input  logic       cfg_addr,
	input  logic       cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // run_end
	output logic       m_tuser    // [0] string_end
);

	entry_t push_entry, head_entry;
	logic   q_push, q_full, q_pop, q_empty;

	// classify and hold escape state
	pcodec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	// decouple the two sides
	pcodec_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (push_entry),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_entry),
		.empty    (q_empty)
	);

	// drain one byte a cycle while m_tready allows
	pcodec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_entry),
		.empty      (q_empty),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.run_end    (m_tlast),
		.string_end (m_tuser)
	);

endmodule

### hw/rtl/pcodec_front.sv
// Percent codec front end: configuration registers, escape tracking and
// classification of each input word into a queue entry. Uses pcodec_pkg.
module pcodec_front import pcodec_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic         cfg_wdata,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   in_byte,
	input  logic         in_last,
	input  logic         q_full,
	output logic         q_push,
	output entry_t       q_entry
);

	logic            decode_mode_q;
	logic            slash_pass_q;
	pend_t           pend_q, pend_nxt;
	logic [7:0]      dig_q, dig_nxt;
	logic [2:0][7:0] res;
	logic [1:0]      n;
	logic            do_plain;
	logic [4:0]      hb, hi;
	logic            accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		res      = '0;
		n        = 2'd0;
		do_plain = 1'b0;
		pend_nxt = pend_q;
		dig_nxt  = dig_q;
		hb       = hex_val(in_byte);
		hi       = hex_val(dig_q);
		if (!decode_mode_q) begin
			if (is_unreserved(in_byte) || (slash_pass_q && in_byte == SLASH_CHAR)) begin
				res[0] = in_byte;
				n      = 2'd1;
			end else begin
				res[0] = PCT_CHAR;
				res[1] = hex_char(in_byte[7:4]);
				res[2] = hex_char(in_byte[3:0]);
				n      = 2'd3;
			end
		end else begin
			case (pend_q)
				PS_PCT: begin
					if (!hb[4]) begin
						pend_nxt = PS_DIG;
						dig_nxt  = in_byte;
					end else begin
						res[0]   = PCT_CHAR;
						n        = 2'd1;
						do_plain = 1'b1;
					end
				end
				PS_DIG: begin
					if (!hi[4] && !hb[4] && {hi[3:0], hb[3:0]} != 8'h00) begin
						res[0]   = {hi[3:0], hb[3:0]};
						n        = 2'd1;
						pend_nxt = PS_IDLE;
					end else begin
						res[0]   = PCT_CHAR;
						res[1]   = dig_q;
						n        = 2'd2;
						do_plain = 1'b1;
					end
				end
				default: do_plain = 1'b1;
			endcase
			if (do_plain) begin
				if (in_byte == PCT_CHAR) begin
					pend_nxt = PS_PCT;
				end else begin
					pend_nxt = PS_IDLE;
					res[n]   = in_byte;
					n        = n + 2'd1;
				end
			end
			// flush a held escape at string end
			if (in_last) begin
				if (pend_nxt == PS_PCT || pend_nxt == PS_DIG) begin
					res[n] = PCT_CHAR;
					n      = n + 2'd1;
				end
				if (pend_nxt == PS_DIG) begin
					res[n] = dig_nxt;
					n      = n + 2'd1;
				end
				pend_nxt = PS_IDLE;
			end
		end
	end

	assign q_entry.bytes = res;
	assign q_entry.cnt   = n;
	assign q_entry.last  = in_last;
	assign q_push        = accept && n != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			slash_pass_q  <= 1'b1;
			pend_q        <= PS_IDLE;
			dig_q         <= 8'h00;
		end else begin
			if (accept) begin
				pend_q <= pend_nxt;
				dig_q  <= dig_nxt;
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_DECODE_MODE: begin
						decode_mode_q <= cfg_wdata;
						pend_q        <= PS_IDLE;
					end
					REG_SLASH_PASS: slash_pass_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

### hw/rtl/pcodec_queue.sv
// Percent codec entry queue: a short FIFO of classified words between the
// front end and the output serialiser. Uses pcodec_pkg for the entry type.
module pcodec_queue import pcodec_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slots_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/pcodec_back.sv
// Percent codec back end: walk the head entry to the output register one
// byte per cycle unless stalled; mark run and string ends. Uses pcodec_pkg.
module pcodec_back import pcodec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_end_q, string_end_q;
	logic       load, take, fin;

	assign load = !valid_q || out_ready;
	assign take = load && !empty;
	assign fin  = idx_q == (head.cnt - 2'd1);
	assign pop  = take && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) valid_q <= !empty;
			if (take) idx_q <= fin ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q       <= head.bytes[idx_q];
			run_end_q    <= fin;
			string_end_q <= fin && head.last;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

endmodule

### hw/rtl/pcodec_chk.sv
// Percent codec port checker and its bind to the top level.
// Watches only the ports of percent_codec; uses pcodec_pkg.
module pcodec_chk import pcodec_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       cfg_addr,
	input logic       cfg_wdata,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	logic mode_q;

	// mirror decode_mode from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we && reg_idx_t'(cfg_addr) == REG_DECODE_MODE) begin
			mode_q <= cfg_wdata;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_end_nest: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("string end without run end");

	a_enc_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !mode_q |-> m_tdata != 8'h00)
		else $error("encoder produced a NUL byte");

endmodule

bind percent_codec pcodec_chk u_pcodec_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_addr  (cfg_addr),
	.cfg_wdata (cfg_wdata),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.m_tuser   (m_tuser)
);
